// ===== src/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants of the text scene tokenizer
// Holds the character codes, lexer modes, token types and result layout.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_OPEN    = 8'h7B;
  localparam logic [7:0] CH_CLOSE   = 8'h7D;

  // result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_NAME    = 3'd4
  } lexer_mode_t;

  typedef enum logic [3:0] {
    TT_UNKNOWN = 4'd0,
    TT_EOF     = 4'd1,
    TT_ENDLINE = 4'd2,
    TT_NAME    = 4'd5,
    TT_STRING  = 4'd6,
    TT_FLOAT   = 4'd7,
    TT_INTEGER = 4'd8,
    TT_OPEN    = 4'd9,
    TT_CLOSE   = 4'd10,
    TT_COMMA   = 4'd11
  } tok_type_t;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] text_char;
    tok_type_t  token_type;
    logic       last_of_input;
  } result_t;

  // results of one step, up to two, packed from slot 0
  typedef struct packed {
    logic [1:0]        count;
    result_t [1:0]     res;
  } step_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= CH_DIGIT_0 && b <= CH_DIGIT_9;
  endfunction

  function automatic result_t mk_text(input logic [7:0] b);
    result_t r;
    r.item_kind     = KIND_TEXT;
    r.text_char     = b;
    r.token_type    = TT_UNKNOWN;
    r.last_of_input = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_done(input tok_type_t t, input logic [7:0] b);
    result_t r;
    r.item_kind     = KIND_DONE;
    r.text_char     = b;
    r.token_type    = t;
    r.last_of_input = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/ast_byte_if.sv =====
// ----------------------------------------------------------------------------
// ast_byte_if: input byte channel
// Valid/ready channel carrying one raw byte or an end-of-input mark.
// ----------------------------------------------------------------------------
interface ast_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

// ===== src/ast_token_if.sv =====
// ----------------------------------------------------------------------------
// ast_token_if: token result channel
// Valid/ready channel carrying one text or completion result.
// ----------------------------------------------------------------------------
interface ast_token_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] text_char;
  logic [3:0] token_type;
  logic       last_of_input;

  modport source (output valid, output item_kind, output text_char, output token_type,
                  output last_of_input, input ready);
  modport sink   (input valid, input item_kind, input text_char, input token_type,
                  input last_of_input, output ready);
endinterface

// ===== src/ast_lexer.sv =====
// ----------------------------------------------------------------------------
// ast_lexer: tokenizer step logic and lexer state
// Turns one registered byte into zero, one or two results and updates mode.
// ----------------------------------------------------------------------------
module ast_lexer import ast_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] byte_in,
  input  logic       end_of_input,
  output step_t      step
);

  lexer_mode_t mode, mode_next;
  logic        is_float, is_float_next;

  // handling of a byte that starts a new token
  logic        ib_emit;
  result_t     ib_res;
  lexer_mode_t ib_mode;
  logic        ib_float;

  always_comb begin
    ib_emit  = 1'b1;
    ib_res   = mk_done(TT_UNKNOWN, byte_in);
    ib_mode  = MODE_IDLE;
    ib_float = 1'b0;
    if (byte_in == CH_TAB || byte_in == CH_CR || byte_in == CH_SPACE) begin
      ib_emit = 1'b0;
    end else if (byte_in == CH_SEMI) begin
      ib_emit = 1'b0;
      ib_mode = MODE_COMMENT;
    end else if (byte_in == CH_LF) begin
      ib_res = mk_done(TT_ENDLINE, 8'h00);
    end else if (byte_in == CH_OPEN) begin
      ib_res = mk_done(TT_OPEN, 8'h00);
    end else if (byte_in == CH_CLOSE) begin
      ib_res = mk_done(TT_CLOSE, 8'h00);
    end else if (byte_in == CH_COMMA) begin
      ib_res = mk_done(TT_COMMA, 8'h00);
    end else if (byte_in == CH_QUOTE) begin
      ib_emit = 1'b0;
      ib_mode = MODE_STRING;
    end else if (is_digit(byte_in) || byte_in == CH_MINUS || byte_in == CH_DOT) begin
      ib_res   = mk_text(byte_in);
      ib_mode  = MODE_NUMBER;
      ib_float = (byte_in == CH_DOT);
    end else if (is_letter(byte_in)) begin
      ib_res  = mk_text(byte_in);
      ib_mode = MODE_NAME;
    end
  end

  tok_type_t num_type;
  assign num_type = is_float ? TT_FLOAT : TT_INTEGER;

  always_comb begin
    step.count    = 2'd0;
    step.res[0]   = mk_text(8'h00);
    step.res[1]   = mk_text(8'h00);
    mode_next     = mode;
    is_float_next = is_float;
    if (end_of_input) begin
      mode_next     = MODE_IDLE;
      is_float_next = 1'b0;
      if (mode == MODE_NUMBER || mode == MODE_NAME) begin
        step.res[0] = mk_done((mode == MODE_NUMBER) ? num_type : TT_NAME, 8'h00);
        step.res[1] = mk_done(TT_EOF, 8'h00);
        step.count  = 2'd2;
      end else begin
        step.res[0] = mk_done(TT_EOF, 8'h00);
        step.count  = 2'd1;
      end
    end else begin
      case (mode)
        MODE_COMMENT: begin
          if (byte_in == CH_LF) begin
            step.res[0] = mk_done(TT_ENDLINE, 8'h00);
            step.count  = 2'd1;
            mode_next   = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          step.count = 2'd1;
          if (byte_in == CH_QUOTE) begin
            step.res[0] = mk_done(TT_STRING, 8'h00);
            mode_next   = MODE_IDLE;
          end else begin
            step.res[0] = mk_text(byte_in);
          end
        end
        MODE_NUMBER: begin
          if (is_digit(byte_in) || byte_in == CH_DOT) begin
            step.res[0] = mk_text(byte_in);
            step.count  = 2'd1;
            if (byte_in == CH_DOT) begin
              is_float_next = 1'b1;
            end
          end else begin
            // close the number, then treat the byte as a fresh start
            step.res[0]   = mk_done(num_type, 8'h00);
            step.res[1]   = ib_res;
            step.count    = ib_emit ? 2'd2 : 2'd1;
            mode_next     = ib_mode;
            is_float_next = ib_float;
          end
        end
        MODE_NAME: begin
          if (is_letter(byte_in) || is_digit(byte_in)) begin
            step.res[0] = mk_text(byte_in);
            step.count  = 2'd1;
          end else if (byte_in == CH_COLON) begin
            step.res[0] = mk_done(TT_NAME, 8'h00);
            step.count  = 2'd1;
            mode_next   = MODE_IDLE;
          end else begin
            step.res[0]   = mk_done(TT_NAME, 8'h00);
            step.res[1]   = ib_res;
            step.count    = ib_emit ? 2'd2 : 2'd1;
            mode_next     = ib_mode;
            is_float_next = ib_float;
          end
        end
        default: begin
          step.res[0]   = ib_res;
          step.count    = ib_emit ? 2'd1 : 2'd0;
          mode_next     = ib_mode;
          is_float_next = ib_float;
        end
      endcase
    end
    // flag the final result of this byte
    if (step.count == 2'd2) begin
      step.res[1].last_of_input = 1'b1;
    end else begin
      step.res[0].last_of_input = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      is_float <= 1'b0;
    end else if (fire) begin
      mode     <= mode_next;
      is_float <= is_float_next;
    end
  end

endmodule

// ===== src/ast_result_queue.sv =====
// ----------------------------------------------------------------------------
// ast_result_queue: result buffer between lexer and output channel
// Takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module ast_result_queue import ast_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  step_t              step,
  output logic               room,
  output logic [LEVEL_W-1:0] level,
  output logic               head_valid,
  output result_t            head,
  input  logic               pop
);

  result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   rd_ptr, wr_ptr;
  logic [LEVEL_W-1:0] level_next;
  logic [1:0]         push_n;
  logic               do_pop;

  assign push_n     = push ? step.count : 2'd0;
  assign head_valid = (level != '0);
  assign do_pop     = pop && head_valid;
  assign head       = entries[rd_ptr];
  // room for a full two-result step regardless of this cycle's pop
  assign room       = (level <= LEVEL_W'(QUEUE_DEPTH - 2));
  assign level_next = level + LEVEL_W'(push_n) - LEVEL_W'(do_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      rd_ptr <= rd_ptr + PTR_W'(do_pop);
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= step.res[0];
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= step.res[1];
    end
  end

endmodule

// ===== src/ascii_scene_tokenizer.sv =====
// ----------------------------------------------------------------------------
// ascii_scene_tokenizer: streaming tokenizer for text scene files
// Splits a byte stream into token text and typed token completions.
//
//   channel       | dir | payload
//   --------------+-----+------------------------------------------------
//   byte_stream   | in  | byte_in, end_of_input
//   token_stream  | out | item_kind, text_char, token_type, last_of_input
//
// One byte per cycle is accepted while the queue has room; a byte is
// registered, lexed from that register and its results written to a
// four-entry queue. A byte with two results takes two output transfers;
// the input stalls only while the queue holds more than two. Synchronous
// reset returns the lexer to idle between tokens and empties the queue.
// ----------------------------------------------------------------------------
module ascii_scene_tokenizer import ast_pkg::*; (
  input logic         clk,
  input logic         rst,
  ast_byte_if.sink    byte_stream,
  ast_token_if.source token_stream
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_eoi;
  logic               fire;
  logic               room;
  logic [LEVEL_W-1:0] level;
  logic               head_valid;
  result_t            head;
  step_t              step;

  assign fire              = in_valid && room;
  assign byte_stream.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      in_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      in_byte <= byte_stream.byte_in;
      in_eoi  <= byte_stream.end_of_input;
    end
  end

  ast_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .byte_in      (in_byte),
    .end_of_input (in_eoi),
    .step         (step)
  );

  ast_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .step       (step),
    .room       (room),
    .level      (level),
    .head_valid (head_valid),
    .head       (head),
    .pop        (token_stream.ready)
  );

  assign token_stream.valid         = head_valid;
  assign token_stream.item_kind     = head.item_kind;
  assign token_stream.text_char     = head.text_char;
  assign token_stream.token_type    = head.token_type;
  assign token_stream.last_of_input = head.last_of_input;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    fire |-> step.count != 2'd3)
    else $error("lexer produced more than two results");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    token_stream.valid && token_stream.item_kind == KIND_DONE &&
    token_stream.token_type == TT_EOF |-> token_stream.last_of_input)
    else $error("end-of-file result not last of its byte");

  a_text_type: assert property (@(posedge clk) disable iff (rst)
    token_stream.valid && token_stream.item_kind == KIND_TEXT |->
    token_stream.token_type == TT_UNKNOWN)
    else $error("text result carries a token type");

endmodule
